@@ hdl/mtte_pkg.sv @@
// package for the multi-tap text entry block
// holds codes, reset values, fsm states and the key cycle tables
// no dependencies
`default_nettype none

package mtte_pkg;

	localparam int MAX_LEN_DEF = 16;
	localparam int DUMP_MAX    = 16;

	localparam int TICK_W = 8;
	localparam int KEY_W  = 5;
	localparam int KIND_W = 3;
	localparam int POS_W  = 4;
	localparam int CHAR_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CYC_W  = 3;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'h20;
	localparam logic [CHAR_W-1:0] NUL_CHAR   = 7'h00;
	localparam logic [KEY_W-1:0]  KEY_FIRST  = 5'd1;
	localparam logic [KEY_W-1:0]  KEY_LAST   = 5'd16;

	localparam logic [TICK_W-1:0] TIMEOUT_RST = 8'd80;
	localparam logic [KEY_W-1:0]  END_RST     = 5'd16;
	localparam logic [KEY_W-1:0]  NEXT_RST    = 5'd15;
	localparam logic [KEY_W-1:0]  DELETE_RST  = 5'd13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMEOUT = 2'd0,
		REG_END     = 2'd1,
		REG_NEXT    = 2'd2,
		REG_DELETE  = 2'd3
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_NONE    = 3'd0,
		KIND_SHOWN   = 3'd1,
		KIND_MOVED   = 3'd2,
		KIND_TEXT    = 3'd3,
		KIND_CLEARED = 3'd4,
		KIND_BLANKED = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADV,
		ST_BLANK,
		ST_MOVED,
		ST_CLEARED,
		ST_DUMP_RD,
		ST_DUMP_OUT,
		ST_SEARCH,
		ST_WRITE
	} state_t;

	// number of characters in the cycle of a key, zero for keys without one
	function automatic logic [CYC_W-1:0] cycle_len(input logic [KEY_W-1:0] key);
		logic [CYC_W-1:0] n;
		n = 3'd0;
		case (key)
			5'd1, 5'd9, 5'd11:                    n = 3'd5;
			5'd2, 5'd3, 5'd5, 5'd6, 5'd7, 5'd10:  n = 3'd4;
			5'd14:                                n = 3'd2;
			default:                              n = 3'd0;
		endcase
		return n;
	endfunction

	// character at place j of the cycle of a key
	function automatic logic [CHAR_W-1:0] cycle_char(input logic [KEY_W-1:0] key,
			input logic [CYC_W-1:0] j);
		logic [CHAR_W-1:0] base;
		logic [CHAR_W-1:0] digit;
		logic [CYC_W-1:0]  nlet;
		logic [CHAR_W-1:0] c;
		base  = NUL_CHAR;
		digit = NUL_CHAR;
		nlet  = 3'd0;
		c     = NUL_CHAR;
		case (key)
			5'd2:    begin base = 7'h41; nlet = 3'd3; digit = 7'h32; end
			5'd3:    begin base = 7'h44; nlet = 3'd3; digit = 7'h33; end
			5'd5:    begin base = 7'h47; nlet = 3'd3; digit = 7'h34; end
			5'd6:    begin base = 7'h4a; nlet = 3'd3; digit = 7'h35; end
			5'd7:    begin base = 7'h4d; nlet = 3'd3; digit = 7'h36; end
			5'd9:    begin base = 7'h50; nlet = 3'd4; digit = 7'h37; end
			5'd10:   begin base = 7'h54; nlet = 3'd3; digit = 7'h38; end
			5'd11:   begin base = 7'h57; nlet = 3'd4; digit = 7'h39; end
			default: begin base = NUL_CHAR; nlet = 3'd0; digit = NUL_CHAR; end
		endcase
		if (key == 5'd1) begin
			case (j)
				3'd0:    c = 7'h5f;
				3'd1:    c = 7'h2e;
				3'd2:    c = 7'h2c;
				3'd3:    c = 7'h31;
				default: c = SPACE_CHAR;
			endcase
		end else if (key == 5'd14) begin
			c = (j == 3'd0) ? 7'h30 : SPACE_CHAR;
		end else if (j < nlet) begin
			c = base + CHAR_W'(j);
		end else begin
			c = digit;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ hdl/multi_tap_text_entry.sv @@
// multi-tap keypad text entry, top level
// uses mtte_pkg and the mtte_ram text buffer
// items are taken one at a time; the end key reads each character from the text ram
// and then transfers it to the output, min(MAX_LEN,16) characters in all
// reset: async active low; cursor 0, timer disarmed, registers to defaults,
// all buffer entries marked invalid so they read back as spaces
`default_nettype none

module multi_tap_text_entry
	import mtte_pkg::*;
#(
	parameter int MAX_LEN = MAX_LEN_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// item input
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  op,
	input  wire logic [KEY_W-1:0]      key_code,
	// result output
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [KIND_W-1:0]     kind,
	output logic      [POS_W-1:0]      position,
	output logic      [CHAR_W-1:0]     char_code,
	output logic                       last,
	// register writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW       = $clog2(MAX_LEN);
	localparam int DUMP_LEN = (MAX_LEN < DUMP_MAX) ? MAX_LEN : DUMP_MAX;
	localparam logic [AW-1:0] CUR_TOP  = AW'(MAX_LEN - 1);
	localparam logic [AW-1:0] DUMP_TOP = AW'(DUMP_LEN - 1);

	// configuration registers
	logic [TICK_W-1:0] timeout_q;
	logic [KEY_W-1:0]  end_key_q;
	logic [KEY_W-1:0]  next_key_q;
	logic [KEY_W-1:0]  del_key_q;

	// sequencer state
	state_t            state_q, state_d;
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [AW-1:0]     cursor_q, cursor_d;
	logic [TICK_W-1:0] idle_q, idle_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [CYC_W-1:0]  j_q, j_d;
	logic [CHAR_W-1:0] nxt_q, nxt_d;

	// per-entry valid bits; an invalid entry reads as a space
	logic [MAX_LEN-1:0] vld_q;
	logic               vld_set, vld_clr_one, vld_clr_all;
	logic               rd_vld_q;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [POS_W-1:0]  pos_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;
	logic              out_free;

	logic              emit;
	kind_t             emit_kind;
	logic [AW-1:0]     emit_pos;
	logic [CHAR_W-1:0] emit_char;
	logic              emit_last;
	logic [AW+POS_W-1:0] emit_pos_ext;

	// text buffer ram
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [CHAR_W-1:0] ram_rdata;
	logic [CHAR_W-1:0] buf_char;

	// compare unit over the key cycle
	logic [CYC_W-1:0]  cyc_len;
	logic [CYC_W-1:0]  j_inc;
	logic [CHAR_W-1:0] cand;
	logic [TICK_W-1:0] tick_cnt;
	logic              key_ok;

	mtte_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (MAX_LEN)
	) u_text_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cursor_q),
		.wdata (nxt_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign position  = pos_q;
	assign char_code = char_q;
	assign last      = last_q;

	assign ram_raddr = (state_q == ST_DUMP_RD) ? idx_q : cursor_q;
	assign buf_char  = rd_vld_q ? ram_rdata : SPACE_CHAR;

	assign cyc_len  = cycle_len(key_q);
	assign j_inc    = j_q + 3'd1;
	assign cand     = cycle_char(key_q, j_q);
	assign tick_cnt = idle_q + 8'd1;
	assign key_ok   = (key_q >= KEY_FIRST) && (key_q <= KEY_LAST);

	// positions are reported in four bits
	assign emit_pos_ext = {{POS_W{1'b0}}, emit_pos};

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			end_key_q  <= END_RST;
			next_key_q <= NEXT_RST;
			del_key_q  <= DELETE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TIMEOUT: timeout_q  <= cfg_data;
				REG_END:     end_key_q  <= cfg_data[KEY_W-1:0];
				REG_NEXT:    next_key_q <= cfg_data[KEY_W-1:0];
				REG_DELETE:  del_key_q  <= cfg_data[KEY_W-1:0];
				default:     timeout_q  <= timeout_q;
			endcase
		end
	end

	// state register and sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= '0;
			idle_q   <= '0;
			idx_q    <= '0;
			j_q      <= '0;
		end else begin
			state_q  <= state_d;
			cursor_q <= cursor_d;
			idle_q   <= idle_d;
			idx_q    <= idx_d;
			j_q      <= j_d;
		end
	end

	// item latch and search result, payload only
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= op;
			key_q <= key_code;
		end
		nxt_q <= nxt_d;
		if (ram_re) begin
			rd_vld_q <= vld_q[ram_raddr];
		end
	end

	// valid bits of the text buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (vld_clr_all) begin
			vld_q <= '0;
		end else if (vld_clr_one) begin
			vld_q[cursor_q] <= 1'b0;
		end else if (vld_set) begin
			vld_q[cursor_q] <= 1'b1;
		end
	end

	// output register: a new result loads only when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= emit_kind;
			pos_q  <= emit_pos_ext[POS_W-1:0];
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	// next state and control
	always_comb begin
		state_d     = state_q;
		cursor_d    = cursor_q;
		idle_d      = idle_q;
		idx_d       = idx_q;
		j_d         = j_q;
		nxt_d       = nxt_q;
		vld_set     = 1'b0;
		vld_clr_one = 1'b0;
		vld_clr_all = 1'b0;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		emit        = 1'b0;
		emit_kind   = KIND_NONE;
		emit_pos    = cursor_q;
		emit_char   = NUL_CHAR;
		emit_last   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end

			ST_DECODE: begin
				state_d = ST_IDLE;
				if (op_q) begin
					// timer tick: only an armed timer counts
					if (idle_q != '0) begin
						if (tick_cnt >= timeout_q) begin
							idle_d  = '0;
							state_d = ST_ADV;
						end else begin
							idle_d = tick_cnt;
						end
					end
				end else if (key_ok) begin
					if (key_q == end_key_q) begin
						idle_d  = '0;
						idx_d   = '0;
						state_d = ST_DUMP_RD;
					end else if (key_q == next_key_q) begin
						idle_d  = '0;
						state_d = ST_ADV;
					end else if (key_q == del_key_q) begin
						idle_d = '0;
						if (cursor_q != '0) begin
							vld_clr_one = 1'b1;
							state_d     = ST_BLANK;
						end else begin
							vld_clr_all = 1'b1;
							state_d     = ST_CLEARED;
						end
					end else begin
						// letter key or unmapped key: arm the timer
						idle_d = 8'd1;
						if (cyc_len != '0) begin
							ram_re  = 1'b1;
							j_d     = '0;
							nxt_d   = cycle_char(key_q, '0);
							state_d = ST_SEARCH;
						end
					end
				end
			end

			ST_SEARCH: begin
				// one cycle entry compared against the stored character per cycle
				if (cand == buf_char) begin
					nxt_d   = (j_inc < cyc_len) ? cycle_char(key_q, j_inc)
						: cycle_char(key_q, '0);
					state_d = ST_WRITE;
				end else if (j_inc >= cyc_len) begin
					state_d = ST_WRITE;
				end else begin
					j_d = j_inc;
				end
			end

			ST_WRITE: begin
				if (out_free) begin
					ram_we    = 1'b1;
					vld_set   = 1'b1;
					emit      = 1'b1;
					emit_kind = KIND_SHOWN;
					emit_char = nxt_q;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end

			ST_ADV: begin
				if (out_free) begin
					if (cursor_q != CUR_TOP) begin
						cursor_d = cursor_q + AW'(1);
					end
					emit      = 1'b1;
					emit_kind = KIND_MOVED;
					emit_pos  = cursor_d;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end

			ST_BLANK: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = KIND_BLANKED;
					emit_char = SPACE_CHAR;
					cursor_d  = cursor_q - AW'(1);
					state_d   = ST_MOVED;
				end
			end

			ST_MOVED: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = KIND_MOVED;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end

			ST_CLEARED: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = KIND_CLEARED;
					emit_pos  = '0;
					emit_char = SPACE_CHAR;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end

			ST_DUMP_RD: begin
				ram_re  = 1'b1;
				state_d = ST_DUMP_OUT;
			end

			ST_DUMP_OUT: begin
				if (out_free) begin
					emit      = 1'b1;
					emit_kind = KIND_TEXT;
					emit_pos  = idx_q;
					emit_char = buf_char;
					emit_last = (idx_q == DUMP_TOP);
					if (idx_q == DUMP_TOP) begin
						cursor_d = '0;
						state_d  = ST_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = ST_DUMP_RD;
					end
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// cursor stays inside the buffer
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= CUR_TOP)
		else $error("cursor beyond buffer");

	// an accepted item is decoded in the next cycle
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DECODE)
		else $error("accepted item not decoded");

	// the final result of an item returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> state_q == ST_IDLE && out_valid_q)
		else $error("sequencer busy after final result");

	// buffer dump data is only used after a ram read
	a_dump_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP_OUT |-> $past(state_q) == ST_DUMP_RD
			|| $past(state_q) == ST_DUMP_OUT)
		else $error("dump output without read");

endmodule

`default_nettype wire

@@ hdl/mtte_ram.sv @@
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module mtte_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
